// ===== hdl/hsv2rgb_pkg.sv =====
// Shared types and fixed-point constants for the HSV to RGB converter.
package hsv2rgb_pkg;

    // Field formats
    localparam int HUE_BITS        = 16;
    localparam int LEVEL_FRAC_BITS = 15;
    localparam int LVL_W           = LEVEL_FRAC_BITS + 1;
    localparam int HUE3_W          = HUE_BITS + 2;      // holds 3*hue
    localparam int NSTG            = 8;                 // pipeline depth

    // Hue constants at three times the hue scale
    localparam logic [HUE3_W-1:0] TURN3     = HUE3_W'(3) << HUE_BITS;
    localparam logic [HUE3_W-1:0] TURN_3W   = HUE3_W'(1) << HUE_BITS;
    localparam logic [HUE3_W-1:0] HALF_3W   = HUE3_W'(1) << (HUE_BITS - 1);
    localparam logic [HUE3_W-1:0] CTR_GREEN = HUE3_W'(1) << HUE_BITS;
    localparam logic [HUE3_W-1:0] CTR_BLUE  = HUE3_W'(2) << HUE_BITS;
    localparam logic [HUE_BITS:0] TURN_H1   = (HUE_BITS + 1)'(1) << HUE_BITS;

    // 1.0 in the level format
    localparam logic [LVL_W-1:0] LVL_ONE = LVL_W'(1) << LEVEL_FRAC_BITS;

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } chan_t;

    typedef struct packed {
        logic [HUE_BITS-1:0] hue_turn;
        logic [LVL_W-1:0]    sat_level;
        logic [LVL_W-1:0]    val_level;
    } hsv_pix_t;

    typedef struct packed {
        logic [LVL_W-1:0] red_level;
        logic [LVL_W-1:0] green_level;
        logic [LVL_W-1:0] blue_level;
    } rgb_pix_t;

    // Per-pixel values carried alongside each channel's pipeline
    typedef struct packed {
        logic [LVL_W-1:0] sat_inv;   // 1 - s
        logic             blend_en;  // s below 1.0
        logic [LVL_W-1:0] val;
    } side_t;

    // Stage load strobes, bit 0 is the first stage
    typedef struct packed {
        logic [NSTG-1:0] load;
    } stg_ctrl_t;

endpackage

// ===== hdl/hsv2rgb_chan.sv =====
// One color channel: hue distance, trapezoid level, saturation blend, value scale.
module hsv2rgb_chan
    import hsv2rgb_pkg::*;
(
    input  logic                clk,
    input  stg_ctrl_t           ctrl,
    input  chan_t               chan,
    input  logic [HUE3_W-1:0]   hue3,
    input  side_t               side,
    output logic [LVL_W-1:0]    level
);

    logic [HUE3_W-1:0]       centre;
    logic [HUE3_W:0]         diff;
    logic [HUE3_W-1:0]       off_next;
    logic [HUE3_W-1:0]       off_reg;
    side_t                   s2_side_reg;

    logic [HUE3_W-1:0]       rev;
    logic [HUE3_W-1:0]       d3_next;
    logic [HUE3_W-1:0]       d3_reg;
    side_t                   s3_side_reg;

    logic [HUE_BITS:0]       ramp;
    logic [HUE_BITS+LVL_W:0] ramp_sh;
    logic [LVL_W-1:0]        c_next;
    logic [LVL_W-1:0]        c4_reg;
    logic [LVL_W-1:0]        cinv_reg;
    side_t                   s4_side_reg;

    logic [2*LVL_W-1:0]      blend_prod_next;
    logic [2*LVL_W-1:0]      blend_prod_reg;
    logic [LVL_W-1:0]        c5_reg;
    side_t                   s5_side_reg;

    logic [LVL_W:0]          cb_next;
    logic [LVL_W:0]          cb_reg;
    logic [LVL_W-1:0]        val6_reg;

    logic [2*LVL_W:0]        scale_prod_next;
    logic [2*LVL_W:0]        scale_prod_reg;

    logic [LVL_W+1:0]        scaled;
    logic [LVL_W-1:0]        level_next;
    logic [LVL_W-1:0]        level_reg;

    // Channel center on the 3*hue scale
    always_comb
    begin
        case (chan)
            CH_RED:   centre = '0;
            CH_GREEN: centre = CTR_GREEN;
            CH_BLUE:  centre = CTR_BLUE;
            default:  centre = '0;
        endcase
    end

    // Stage 2: offset from center, wrapped into one turn
    always_comb
    begin
        diff = {1'b0, hue3} - {1'b0, centre};
        if (diff[HUE3_W])
            off_next = diff[HUE3_W-1:0] + TURN3;
        else
            off_next = diff[HUE3_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[1])
        begin
            off_reg     <= off_next;
            s2_side_reg <= side;
        end
    end

    // Stage 3: circular distance
    always_comb
    begin
        rev     = TURN3 - off_reg;
        d3_next = (off_reg > rev) ? rev : off_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[2])
        begin
            d3_reg      <= d3_next;
            s3_side_reg <= s2_side_reg;
        end
    end

    // Stage 4: trapezoid level, flat top, linear ramp, zero beyond
    always_comb
    begin
        ramp    = TURN_H1 - d3_reg[HUE_BITS:0];
        ramp_sh = {ramp, {LVL_W{1'b0}}};
        if (d3_reg < HALF_3W)
            c_next = LVL_ONE;
        else if (d3_reg < TURN_3W)
            c_next = ramp_sh[HUE_BITS+LVL_W-1:HUE_BITS];
        else
            c_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[3])
        begin
            c4_reg      <= c_next;
            cinv_reg    <= LVL_ONE - c_next;
            s4_side_reg <= s3_side_reg;
        end
    end

    // Stage 5: (1 - s)(1 - c)
    assign blend_prod_next = s4_side_reg.sat_inv * cinv_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[4])
        begin
            blend_prod_reg <= blend_prod_next;
            c5_reg         <= c4_reg;
            s5_side_reg    <= s4_side_reg;
        end
    end

    // Stage 6: blend toward 1.0 when saturation is below one
    always_comb
    begin
        if (s5_side_reg.blend_en)
            cb_next = {1'b0, c5_reg}
                    + blend_prod_reg[2*LVL_W-1:LEVEL_FRAC_BITS];
        else
            cb_next = {1'b0, c5_reg};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[5])
        begin
            cb_reg   <= cb_next;
            val6_reg <= s5_side_reg.val;
        end
    end

    // Stage 7: scale by value
    assign scale_prod_next = cb_reg * val6_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[6])
            scale_prod_reg <= scale_prod_next;
    end

    // Stage 8: drop fraction and clamp to 1.0
    always_comb
    begin
        scaled = scale_prod_reg[2*LVL_W:LEVEL_FRAC_BITS];
        if (scaled > {2'b00, LVL_ONE})
            level_next = LVL_ONE;
        else
            level_next = scaled[LVL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[7])
            level_reg <= level_next;
    end

    assign level = level_reg;

endmodule

// ===== hdl/hsv_to_rgb_converter.sv =====
// Top level of the HSV to RGB converter: input stage, stage control, three channels.
//
//  Channel | Valid     | Stall     | Payload
//  --------+-----------+-----------+--------------------------------------------
//  HSV in  | hsv_valid | hsv_stall | hsv (hue_turn, sat_level, val_level)
//  RGB out | rgb_valid | rgb_stall | rgb (red_level, green_level, blue_level)
//
//  One pixel per clock while rgb_stall lets the stages move; each pixel passes eight stages
//  (3*hue, offset, distance, level, blend product, blend, scale product, clamp).
//  Each stage loads when it is empty or the stage after it moves, so bubbles
//  collapse and the input keeps flowing while the output register waits.
//  hsv_stall rises only when all eight stages hold pixels and rgb is stalled.
//  Reset clears the stage valid bits; no clearing pass is needed.
module hsv_to_rgb_converter
    import hsv2rgb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     hsv_valid,
    output logic     hsv_stall,
    input  hsv_pix_t hsv,
    output logic     rgb_valid,
    input  logic     rgb_stall,
    output rgb_pix_t rgb
);

    logic [NSTG-1:0]   valid_reg;
    logic [NSTG-1:0]   valid_next;
    logic [NSTG-1:0]   ready;
    stg_ctrl_t         ctrl;

    logic [HUE3_W-1:0] hue3_next;
    logic [HUE3_W-1:0] hue3_reg;
    side_t             side_next;
    side_t             side_reg;

    // Stage ready chain, last stage first
    always_comb
    begin
        ready[NSTG-1] = !valid_reg[NSTG-1] || !rgb_stall;
        for (int k = NSTG - 2; k >= 0; k--)
            ready[k] = !valid_reg[k] || ready[k+1];
    end

    assign ctrl.load = ready;
    assign hsv_stall = !ready[0];

    // Valid bits advance with the data
    always_comb
    begin
        valid_next = valid_reg;
        if (ready[0])
            valid_next[0] = hsv_valid;
        for (int k = 1; k < NSTG; k++)
        begin
            if (ready[k])
                valid_next[k] = valid_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    // Stage 1: 3*hue, inverse saturation and blend enable
    always_comb
    begin
        hue3_next          = {2'b00, hsv.hue_turn} + {1'b0, hsv.hue_turn, 1'b0};
        side_next.sat_inv  = LVL_ONE - hsv.sat_level;
        side_next.blend_en = hsv.sat_level < LVL_ONE;
        side_next.val      = hsv.val_level;
    end

    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            hue3_reg <= hue3_next;
            side_reg <= side_next;
        end
    end

    // Channel pipelines
    hsv2rgb_chan u_red
    (
        .clk   (clk),
        .ctrl  (ctrl),
        .chan  (CH_RED),
        .hue3  (hue3_reg),
        .side  (side_reg),
        .level (rgb.red_level)
    );

    hsv2rgb_chan u_green
    (
        .clk   (clk),
        .ctrl  (ctrl),
        .chan  (CH_GREEN),
        .hue3  (hue3_reg),
        .side  (side_reg),
        .level (rgb.green_level)
    );

    hsv2rgb_chan u_blue
    (
        .clk   (clk),
        .ctrl  (ctrl),
        .chan  (CH_BLUE),
        .hue3  (hue3_reg),
        .side  (side_reg),
        .level (rgb.blue_level)
    );

    assign rgb_valid = valid_reg[NSTG-1];

    // Input stalls only with a full pipeline
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_stall |-> (&valid_reg))
        else $error("input stalled with an empty stage");

    // Accepted pixel occupies the first stage
    a_accept_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (hsv_valid && !hsv_stall) |=> valid_reg[0])
        else $error("accepted pixel lost at first stage");

    // Outputs stay within 0..1
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid |-> (rgb.red_level <= LVL_ONE && rgb.green_level <= LVL_ONE
                       && rgb.blue_level <= LVL_ONE))
        else $error("channel level above 1.0");

endmodule

// ===== sim/hsv_pixel_checker.sv =====
// Checker for the HSV to RGB converter: predicts each pixel and compares the results.
module hsv_pixel_checker
    import hsv2rgb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     hsv_valid,
    input  logic     hsv_stall,
    input  hsv_pix_t hsv,
    input  logic     rgb_valid,
    input  logic     rgb_stall,
    input  rgb_pix_t rgb,
    output int       mismatch_count,
    output int       rgb_backlog
);
    timeunit 1ns;
    timeprecision 1ps;

    // Fixed-point scales; hue distances are kept at three times the hue scale
    localparam longint unsigned TURN  = 64'd1 << HUE_BITS;
    localparam longint unsigned SPAN3 = 3 * TURN;
    localparam longint unsigned ONE   = 64'd1 << LEVEL_FRAC_BITS;

    rgb_pix_t pending_rgb[$];

    // One channel: trapezoid on circular hue distance, saturation blend, value scale
    function automatic logic [LVL_W-1:0] shade_level(longint unsigned hue3, chan_t ch,
                                                     longint unsigned sat,
                                                     longint unsigned val);
        longint unsigned off3;
        longint unsigned d3;
        longint unsigned lvl;
        longint unsigned scaled;
        off3 = (hue3 + SPAN3 - TURN * ch) % SPAN3;
        d3   = (off3 > SPAN3 - off3) ? SPAN3 - off3 : off3;
        if (2 * d3 < TURN)
            lvl = ONE;
        else if (d3 < TURN)
            lvl = ((2 * TURN - 2 * d3) * ONE) >> HUE_BITS;
        else
            lvl = 0;
        // saturation of one or more leaves the level untouched
        if (sat < ONE)
            lvl += ((ONE - sat) * (ONE - lvl)) >> LEVEL_FRAC_BITS;
        scaled = (lvl * val) >> LEVEL_FRAC_BITS;
        if (scaled > ONE)
            scaled = ONE;
        return scaled[LVL_W-1:0];
    endfunction

    function automatic rgb_pix_t rgb_from_hsv(hsv_pix_t p);
        rgb_pix_t        q;
        longint unsigned hue3;
        hue3          = 3 * longint'(p.hue_turn);
        q.red_level   = shade_level(hue3, CH_RED, p.sat_level, p.val_level);
        q.green_level = shade_level(hue3, CH_GREEN, p.sat_level, p.val_level);
        q.blue_level  = shade_level(hue3, CH_BLUE, p.sat_level, p.val_level);
        return q;
    endfunction

    // Compare each accepted output transaction, then queue the prediction for a new input
    always @(posedge clk)
    begin : track
        rgb_pix_t want;
        if (rst_n)
        begin
            if (rgb_valid && !rgb_stall)
            begin
                if (pending_rgb.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("%0t: unexpected rgb transaction r=%0d g=%0d b=%0d",
                                 $realtime, rgb.red_level, rgb.green_level, rgb.blue_level);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = pending_rgb.pop_front();
                    if (rgb.red_level !== want.red_level ||
                        rgb.green_level !== want.green_level ||
                        rgb.blue_level !== want.blue_level)
                    begin
                        if (mismatch_count < 10)
                            $display("%0t: rgb mismatch exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                                     $realtime, want.red_level, want.green_level,
                                     want.blue_level, rgb.red_level, rgb.green_level,
                                     rgb.blue_level);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (hsv_valid && !hsv_stall)
                pending_rgb.push_back(rgb_from_hsv(hsv));
            rgb_backlog <= pending_rgb.size();
        end
    end

endmodule

// ===== sim/tb_hsv_to_rgb_converter.sv =====
// Testbench top for the HSV to RGB converter: clock, reset, stimulus and verdict.
module tb_hsv_to_rgb_converter
    import hsv2rgb_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PIXELS  = 1230;
    localparam int DRAIN_CYCLES   = 32;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 100;
    localparam logic [LVL_W-1:0] FULL = LVL_ONE;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     hsv_valid;
    logic     hsv_stall;
    hsv_pix_t hsv;
    logic     rgb_valid;
    logic     rgb_stall;
    rgb_pix_t rgb;

    int mismatch_count;
    int rgb_backlog;
    int pixels_sent = 0;
    int burst_left  = 0;

    always #2 clk = ~clk;

    hsv_to_rgb_converter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .hsv_valid (hsv_valid),
        .hsv_stall (hsv_stall),
        .hsv       (hsv),
        .rgb_valid (rgb_valid),
        .rgb_stall (rgb_stall),
        .rgb       (rgb)
    );

    hsv_pixel_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .hsv_valid      (hsv_valid),
        .hsv_stall      (hsv_stall),
        .hsv            (hsv),
        .rgb_valid      (rgb_valid),
        .rgb_stall      (rgb_stall),
        .rgb            (rgb),
        .mismatch_count (mismatch_count),
        .rgb_backlog    (rgb_backlog)
    );

    function automatic hsv_pix_t pix(int h, int s, int v);
        hsv_pix_t p;
        p.hue_turn  = h[HUE_BITS-1:0];
        p.sat_level = s[LVL_W-1:0];
        p.val_level = v[LVL_W-1:0];
        return p;
    endfunction

    // Mostly in range, some extremes, some with every field bit random
    function automatic int random_level();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            case ($urandom_range(0, 3))
                0: return 0;
                1: return 1;
                2: return LVL_ONE - 1;
                default: return LVL_ONE;
            endcase
        end
        else if (r < 25)
            return $urandom_range(0, (1 << LVL_W) - 1);
        return $urandom_range(0, LVL_ONE);
    endfunction

    // Offer one pixel, wait for acceptance, then maybe open a gap
    task automatic send_pixel(hsv_pix_t p);
        int r;
        int gap;
        hsv_valid <= 1'b1;
        hsv       <= p;
        do
            @(posedge clk);
        while (!(hsv_valid && !hsv_stall));
        pixels_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 50);
            r = $urandom_range(0, 9);
            if (r < 4)
                gap = 0;
            else if (r < 8)
                gap = $urandom_range(1, 4);
            else if (r < 9)
                gap = $urandom_range(5, 20);
            else
                gap = 30;
            if (gap > 0)
            begin
                hsv_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stimulus: reset, directed corners, random pixels, drain, verdict
    initial
    begin
        int h;
        int k;
        rst_n     = 1'b0;
        hsv_valid = 1'b0;
        hsv       = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // channel centers, hue wrap, plateau and ramp edges
        send_pixel(pix(0, FULL, FULL));
        send_pixel(pix(21845, FULL, FULL));
        send_pixel(pix(21846, FULL, FULL));
        send_pixel(pix(43691, FULL, FULL));
        send_pixel(pix(65535, FULL, FULL));
        send_pixel(pix(10922, FULL, FULL));
        send_pixel(pix(10923, FULL, FULL));
        send_pixel(pix(5461, FULL, FULL));
        send_pixel(pix(32768, FULL, FULL));
        // saturation: none, partial, just below one, above one
        send_pixel(pix(0, 0, FULL));
        send_pixel(pix(21000, 0, FULL));
        send_pixel(pix(12000, 16384, FULL));
        send_pixel(pix(12000, 32767, FULL));
        send_pixel(pix(12000, 32769, FULL));
        send_pixel(pix(12000, 65535, FULL));
        // value: zero, tiny, above one so the level clamps
        send_pixel(pix(12000, 16384, 0));
        send_pixel(pix(12000, 16384, 1));
        send_pixel(pix(12000, 16384, 32769));
        send_pixel(pix(12000, 0, 65535));
        send_pixel(pix(54613, 8192, 20000));
        send_pixel(pix(65535, 65535, 65535));
        send_pixel(pix(0, 0, 0));

        // random pixels, a quarter of the hues near a sixth-turn boundary
        repeat (RANDOM_PIXELS)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                k = $urandom_range(0, 5);
                h = (k * 65536) / 6 + $urandom_range(0, 6) - 3;
            end
            else
                h = $urandom_range(0, 65535);
            send_pixel(pix(h, random_level(), random_level()));
        end
        hsv_valid <= 1'b0;

        @(posedge clk);
        while (rgb_backlog != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Output stall pattern, with long hold-offs so the pipeline backs up
    initial
    begin
        int mode;
        int len;
        int tick;
        int next_hold_at;
        rgb_stall    = 1'b0;
        next_hold_at = 200;
        tick         = 0;
        forever
        begin
            if (pixels_sent >= next_hold_at)
            begin
                next_hold_at += 450;
                rgb_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(10, 120);
                repeat (len)
                begin
                    tick++;
                    case (mode)
                        0: rgb_stall <= 1'b0;
                        1: rgb_stall <= ($urandom_range(0, 99) < 30);
                        2: rgb_stall <= ($urandom_range(0, 99) < 75);
                        default: rgb_stall <= tick[0];
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // Watchdog: too many cycles with no transaction on either channel
    initial
    begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((hsv_valid && !hsv_stall) || (rgb_valid && !rgb_stall))
                idle = 0;
            else
                idle++;
        end
        $display("TEST FAILED");
        $finish;
    end

endmodule
